FILE: hdl/utx_pkg.sv
// Package for the UART 8N1 transceiver: item structs, register map and
// timing constants. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package utx_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned BITS_W = 4;

  localparam logic [CNT_W-1:0] BIT_CYCLES_RESET = 16'd104;
  localparam logic [CNT_W-1:0] MIN_BIT_CYCLES = 16'd4;

  // frame: start bit, eight data bits, stop bit
  localparam logic [BITS_W-1:0] TX_BITS_PER_FRAME = 4'd9;
  localparam logic [BITS_W-1:0] RX_DATA_BITS = 4'd8;
  localparam logic [BITS_W-1:0] RX_HALF_WAIT = 4'd9;

  // register index, taken from paddr[2]
  localparam logic REG_BIT_CYCLES = 1'b0;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       rx_line;
  } utx_in_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_busy;
    logic       send_accepted;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } utx_out_t;

  typedef struct packed {
    logic tx_line;
    logic tx_busy;
    logic send_accepted;
  } utx_tx_res_t;

  typedef struct packed {
    logic       rx_valid;
    logic [7:0] rx_byte;
  } utx_rx_res_t;

endpackage

FILE: hdl/uart_8n1_transceiver_unit.sv
// Top level of the UART 8N1 transceiver: config register, transmitter,
// receiver and result register. Depends on utx_pkg, utx_tx and utx_rx.
//
//   channel  | direction | handshake              | payload
//   in       | input     | in_valid / in_stall    | in_item  (utx_in_t)
//   out      | output    | out_valid / out_stall  | out_item (utx_out_t)
//   config   | input     | APB write/read         | bit_cycles at address 0
//
// One item per cycle while in_stall is low; the output register takes its
// result on acceptance, set by the single state update of both timers.
// Reset is synchronous and puts both sides idle with bit_cycles at 104.
// in_stall rises only while a result is held in the output register under
// out_stall, so the input takes an item in the same cycle the result leaves.
`timescale 1ns / 1ps

module uart_8n1_transceiver_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  utx_pkg::utx_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output utx_pkg::utx_out_t out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import utx_pkg::*;

  logic [CNT_W-1:0] bit_cycles;
  logic [CNT_W-1:0] period;
  logic             step;
  utx_tx_res_t      tx_res;
  utx_rx_res_t      rx_res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cycles <= BIT_CYCLES_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BIT_CYCLES) begin
      bit_cycles <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BIT_CYCLES) ? {{(32-CNT_W){1'b0}}, bit_cycles} : '0;

  // clamp short bit periods
  assign period = (bit_cycles < MIN_BIT_CYCLES) ? MIN_BIT_CYCLES : bit_cycles;

  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;

  utx_tx u_tx (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .period     (period),
    .send_valid (in_item.send_valid),
    .send_byte  (in_item.send_byte),
    .res        (tx_res)
  );

  utx_rx u_rx (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .period  (period),
    .rx_line (in_item.rx_line),
    .res     (rx_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item.tx_line       <= tx_res.tx_line;
      out_item.tx_busy       <= tx_res.tx_busy;
      out_item.send_accepted <= tx_res.send_accepted;
      out_item.rx_valid      <= rx_res.rx_valid;
      out_item.rx_byte       <= rx_res.rx_byte;
    end
  end

endmodule

FILE: hdl/utx_tx.sv
// Transmit framer: shift register, bit counter and bit timer.
// Depends on utx_pkg.
`timescale 1ns / 1ps

module utx_tx (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [utx_pkg::CNT_W-1:0] period,
  input  logic                      send_valid,
  input  logic [7:0]                send_byte,
  output utx_pkg::utx_tx_res_t      res
);
  import utx_pkg::*;

  logic [9:0]        tx_shift, tx_shift_next;
  logic [BITS_W-1:0] tx_bits_left, tx_bits_left_next;
  logic [CNT_W-1:0]  tx_tick_count, tx_tick_count_next;
  logic              tx_out, tx_out_next;
  logic              accepted;

  always_comb begin
    tx_shift_next      = tx_shift;
    tx_bits_left_next  = tx_bits_left;
    tx_tick_count_next = tx_tick_count;
    tx_out_next        = tx_out;
    accepted           = 1'b0;
    if (tx_tick_count != '0) begin
      tx_tick_count_next = tx_tick_count - 1'b1;
      // bit period over: advance to the next bit of the frame
      if (tx_tick_count_next == '0 && tx_bits_left != '0) begin
        tx_out_next        = tx_shift[0];
        tx_shift_next      = {1'b1, tx_shift[9:1]};
        tx_bits_left_next  = tx_bits_left - 1'b1;
        tx_tick_count_next = period;
      end
    end
    // a request while busy is dropped
    if (send_valid && tx_tick_count_next == '0) begin
      tx_out_next        = 1'b0;
      tx_shift_next      = {2'b11, send_byte};
      tx_bits_left_next  = TX_BITS_PER_FRAME;
      tx_tick_count_next = period;
      accepted           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift      <= '1;
      tx_bits_left  <= '0;
      tx_tick_count <= '0;
      tx_out        <= 1'b1;
    end else if (step) begin
      tx_shift      <= tx_shift_next;
      tx_bits_left  <= tx_bits_left_next;
      tx_tick_count <= tx_tick_count_next;
      tx_out        <= tx_out_next;
    end
  end

  assign res.tx_line       = tx_out_next;
  assign res.tx_busy       = (tx_tick_count_next != '0);
  assign res.send_accepted = accepted;

  a_idle_no_bits: assert property (@(posedge clk) disable iff (rst)
    tx_tick_count == '0 |-> tx_bits_left == '0)
    else $error("transmit timer idle with bits pending");

  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    tx_bits_left <= TX_BITS_PER_FRAME)
    else $error("transmit bit count out of range");

  a_start_bit: assert property (@(posedge clk) disable iff (rst)
    step && accepted |=> tx_tick_count != '0 && !tx_out)
    else $error("accepted send did not start a frame");

endmodule

FILE: hdl/utx_rx.sv
// Receive sampler: start-edge hunt, half and full bit timers, shift register.
// Depends on utx_pkg.
`timescale 1ns / 1ps

module utx_rx (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [utx_pkg::CNT_W-1:0] period,
  input  logic                      rx_line,
  output utx_pkg::utx_rx_res_t      res
);
  import utx_pkg::*;

  logic [7:0]        rx_shift, rx_shift_next;
  logic [BITS_W-1:0] rx_bits_left, rx_bits_left_next;
  logic [CNT_W-1:0]  rx_tick_count, rx_tick_count_next;
  logic              rx_hunting, rx_hunting_next;
  logic              rx_prev_line;
  logic              got;

  always_comb begin
    rx_shift_next      = rx_shift;
    rx_bits_left_next  = rx_bits_left;
    rx_tick_count_next = rx_tick_count;
    rx_hunting_next    = rx_hunting;
    got                = 1'b0;
    if (rx_hunting) begin
      if (rx_prev_line && !rx_line) begin
        rx_hunting_next    = 1'b0;
        rx_bits_left_next  = RX_HALF_WAIT;
        rx_tick_count_next = period >> 1;
      end
    end else begin
      if (rx_tick_count != '0) begin
        rx_tick_count_next = rx_tick_count - 1'b1;
      end
      if (rx_tick_count_next == '0) begin
        if (rx_bits_left > RX_DATA_BITS || rx_bits_left == '0) begin
          // half wait done: one full period to the first data bit
          rx_bits_left_next  = RX_DATA_BITS;
          rx_tick_count_next = period;
        end else begin
          rx_shift_next      = {rx_line, rx_shift[7:1]};
          rx_bits_left_next  = rx_bits_left - 1'b1;
          rx_tick_count_next = period;
          if (rx_bits_left_next == '0) begin
            got                = 1'b1;
            rx_bits_left_next  = RX_DATA_BITS;
            rx_hunting_next    = 1'b1;
            rx_tick_count_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_shift      <= '0;
      rx_bits_left  <= RX_DATA_BITS;
      rx_tick_count <= '0;
      rx_hunting    <= 1'b1;
      rx_prev_line  <= 1'b1;
    end else if (step) begin
      rx_shift      <= rx_shift_next;
      rx_bits_left  <= rx_bits_left_next;
      rx_tick_count <= rx_tick_count_next;
      rx_hunting    <= rx_hunting_next;
      rx_prev_line  <= rx_line;
    end
  end

  assign res.rx_valid = got;
  assign res.rx_byte  = got ? rx_shift_next : 8'h00;

  a_hunt_clean: assert property (@(posedge clk) disable iff (rst)
    rx_hunting |-> rx_bits_left == RX_DATA_BITS && rx_tick_count == '0)
    else $error("receiver hunting with stale counters");

  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    rx_bits_left <= RX_HALF_WAIT && rx_bits_left != '0)
    else $error("receive bit count out of range");

  a_done_hunts: assert property (@(posedge clk) disable iff (rst)
    step && got |=> rx_hunting)
    else $error("receiver did not return to hunting after a byte");

endmodule
